// ----- src/rbf_pkg.sv -----
// Shared types and constants for the ring buffer FIFO.
// No dependencies; rbf_if.sv and ring_buffer_fifo.sv use this package.
package rbf_pkg;

  // Commands carried on the input channel
  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // Status codes on the result channel
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Fixed field widths of the channels
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned FILL_W  = 11;
  localparam int unsigned CAPLG_W = 4;

  // Capacity register value after reset
  localparam logic [CAPLG_W-1:0] CAP_LOG2_RESET = 4'd10;

  // Defaults for the top-level parameters
  localparam int unsigned DEFAULT_MAX_DEPTH    = 1024;
  localparam int unsigned DEFAULT_ELEMENT_BITS = 32;

endpackage

// ----- src/rbf_if.sv -----
// Valid/ready channel interfaces for the ring buffer FIFO command and result beats.
// Depends on rbf_pkg for the field widths.
interface rbf_in_if;
  logic                       valid;
  logic                       ready;
  logic [rbf_pkg::CMD_W-1:0]  command;
  logic [rbf_pkg::WORD_W-1:0] push_data;

  modport source (output valid, command, push_data, input ready);
  modport sink   (input valid, command, push_data, output ready);
endinterface

interface rbf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [rbf_pkg::WORD_W-1:0] read_data;
  logic [rbf_pkg::FILL_W-1:0] fill_count;
  logic                       is_empty;
  logic                       is_full;

  modport source (output valid, status, read_data, fill_count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, status, read_data, fill_count, is_empty, is_full,
                  output ready);
endinterface

// ----- src/ring_buffer_fifo.sv -----
// Ring buffer FIFO top level: pointer and count control around the element memory.
// Depends on rbf_pkg, rbf_in_if/rbf_out_if and rbf_store.
//
// A circular queue of ELEMENT_BITS-wide words with a capacity of 2^capacity_log2
// entries, saturated at MAX_DEPTH. Each command beat (push, pop, peek, clear) gives
// exactly one result beat. The block takes one command beat per clock cycle unless
// the result channel stalls; the result appears in the cycle after acceptance, with
// the head element read from memory. A command is accepted whenever the result
// register is empty or its beat is taken in the same cycle. Head, tail and count live
// in flip-flops and are updated in the accepting cycle, so back-to-back commands see
// each other's effects; the memory needs no clearing pass after reset, since only
// written entries are ever read. Writing the capacity register empties the queue.
module ring_buffer_fifo #(
  parameter int unsigned MAX_DEPTH    = rbf_pkg::DEFAULT_MAX_DEPTH,
  parameter int unsigned ELEMENT_BITS = rbf_pkg::DEFAULT_ELEMENT_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  rbf_in_if.sink                       in_ch,
  rbf_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [rbf_pkg::CAPLG_W-1:0]  cfg_wdata
);

  localparam int unsigned AW = $clog2(MAX_DEPTH);
  localparam int unsigned CW = AW + 1;

  // capacity in use for a given log2 value, saturated at MAX_DEPTH
  function automatic logic [CW-1:0] cap_of(input logic [rbf_pkg::CAPLG_W-1:0] k);
    logic [CW-1:0] c;
    if (32'(k) >= AW) begin
      c = CW'(MAX_DEPTH);
    end else begin
      c = CW'(1) << k;
    end
    return c;
  endfunction

  // queue state
  logic [CW-1:0] cap_r, cap_nxt;
  logic [AW-1:0] mask_r, mask_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // result register
  logic          out_valid_r, out_valid_nxt;
  logic          status_r, status_nxt;
  logic          use_mem_r, use_mem_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          empty_r, empty_nxt;
  logic          full_r, full_nxt;

  logic              in_acc;
  logic              out_acc;
  rbf_pkg::cmd_t     cmd;
  logic              mem_we;
  logic              mem_re;
  logic [ELEMENT_BITS-1:0] mem_wdata;
  logic [ELEMENT_BITS-1:0] mem_rdata;

  assign out_acc      = out_valid_r && out_ch.ready;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cmd          = rbf_pkg::cmd_t'(in_ch.command);
  assign mem_wdata    = ELEMENT_BITS'(in_ch.push_data);

  // command decode, pointer and count update
  always_comb begin
    cap_nxt       = cap_r;
    mask_nxt      = mask_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_acc;
    status_nxt    = status_r;
    use_mem_nxt   = use_mem_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    if (in_acc) begin
      out_valid_nxt = 1'b1;
      status_nxt    = rbf_pkg::STATUS_OK;
      use_mem_nxt   = 1'b0;
      case (cmd)
        rbf_pkg::CMD_PUSH: begin
          if (count_r == cap_r) begin
            status_nxt = rbf_pkg::STATUS_FAIL;
          end else begin
            mem_we    = 1'b1;
            tail_nxt  = (tail_r + AW'(1)) & mask_r;
            count_nxt = count_r + CW'(1);
          end
        end
        rbf_pkg::CMD_POP,
        rbf_pkg::CMD_PEEK: begin
          if (count_r == '0) begin
            status_nxt = rbf_pkg::STATUS_FAIL;
          end else begin
            mem_re      = 1'b1;
            use_mem_nxt = 1'b1;
            if (cmd == rbf_pkg::CMD_POP) begin
              head_nxt  = (head_r + AW'(1)) & mask_r;
              count_nxt = count_r - CW'(1);
            end
          end
        end
        default: begin
          head_nxt  = '0;
          tail_nxt  = '0;
          count_nxt = '0;
        end
      endcase
    end

    // capacity write empties the queue
    if (cfg_we) begin
      cap_nxt   = cap_of(cfg_wdata);
      mask_nxt  = AW'(cap_of(cfg_wdata) - CW'(1));
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end
  end

  // flags after the command
  always_comb begin
    fill_nxt  = fill_r;
    empty_nxt = empty_r;
    full_nxt  = full_r;
    if (in_acc) begin
      fill_nxt  = count_nxt;
      empty_nxt = (count_nxt == '0);
      full_nxt  = (count_nxt == cap_r);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= cap_of(rbf_pkg::CAP_LOG2_RESET);
      mask_r      <= AW'(cap_of(rbf_pkg::CAP_LOG2_RESET) - CW'(1));
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      mask_r      <= mask_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    use_mem_r <= use_mem_nxt;
    fill_r    <= fill_nxt;
    empty_r   <= empty_nxt;
    full_r    <= full_nxt;
  end

  rbf_store #(
    .DEPTH (MAX_DEPTH),
    .WIDTH (ELEMENT_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail_r),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (head_r),
    .rdata (mem_rdata)
  );

  // result channel
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.read_data  = use_mem_r ? rbf_pkg::WORD_W'(mem_rdata) : '0;
  assign out_ch.fill_count = rbf_pkg::FILL_W'(fill_r);
  assign out_ch.is_empty   = empty_r;
  assign out_ch.is_full    = full_r;

  // the count never exceeds the capacity in use
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("element count above capacity");

  // head plus count lands on the tail, modulo the capacity
  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    ((head_r + count_r[AW-1:0]) & mask_r) == tail_r)
    else $error("head, tail and count disagree");

  // a successful pop takes exactly one element
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_we && cmd == rbf_pkg::CMD_POP && count_r != '0)
      |=> count_r == $past(count_r) - CW'(1))
    else $error("pop did not decrement the count");

  // every accepted command beat leaves a result beat pending
  a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted command produced no result");

endmodule

// ----- src/rbf_store.sv -----
// Element storage of the ring buffer FIFO: one write port, one registered read port.
// Depends on nothing but its parameters.
module rbf_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data registered and held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
